// ===== design/tagged_tlb_fifo_lru_core_assert.svh =====
// Assertion macros used by the core RTL file.
`ifndef TAGGED_TLB_FIFO_LRU_CORE_ASSERT_SVH
`define TAGGED_TLB_FIFO_LRU_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TTLB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define TTLB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ttlb_pkg.sv =====
`default_nettype none

package ttlb_pkg;

   // Sizes
   localparam int DEF_ENTRIES = 64;
   localparam int MAX_USED    = 128;   // active size register cannot reach beyond this
   localparam int CMD_W       = 3;
   localparam int PID_W       = 32;
   localparam int PAGE_W      = 52;
   localparam int FRAME_W     = 32;
   localparam int STAMP_W     = 64;
   localparam int SLOT_W      = 6;
   localparam int ACT_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;

   // Commands
   localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INV_ONE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INV_PROC = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE = 1'b1;

   localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

   // One table entry as kept in the RAM
   typedef struct packed {
      logic [PID_W-1:0]   proc_id;
      logic [PAGE_W-1:0]  page_num;
      logic [FRAME_W-1:0] frame_num;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== design/tagged_tlb_fifo_lru_core.sv =====
// Each command sweeps the active entries (ST_SCAN) through the single read port of
//   the entry RAM, then passes ST_TAIL and ST_DONE; the result word is registered out
//   of ST_DONE. busy holds off a new command until the last one is done.
// Reset clears valid bits, FIFO pointer, access counter and the two registers
//   (FIFO policy, 64 active); RAM contents are not cleared. Results cannot stall.
`default_nettype none
`include "tagged_tlb_fifo_lru_core_assert.svh"

module tagged_tlb_fifo_lru_core #(
   parameter int ENTRIES = ttlb_pkg::DEF_ENTRIES
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // command channel
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [ttlb_pkg::CMD_W-1:0]       req_command,
   input  wire logic [ttlb_pkg::PID_W-1:0]       req_process_id,
   input  wire logic [ttlb_pkg::PAGE_W-1:0]      req_page_number,
   input  wire logic [ttlb_pkg::FRAME_W-1:0]     req_frame_number,
   // result channel
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic      [ttlb_pkg::FRAME_W-1:0]     rsp_found_frame,
   output logic      [ttlb_pkg::SLOT_W-1:0]      rsp_slot_index,
   // register writes
   input  wire logic                             csr_we,
   input  wire logic [ttlb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ttlb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import ttlb_pkg::*;

   localparam int USED = (ENTRIES < MAX_USED) ? ENTRIES : MAX_USED;
   localparam int IW   = (USED > 1) ? $clog2(USED) : 1;
   localparam int CW   = $clog2(USED + 1);
   localparam int CMPW = CW + 1;
   localparam int SX   = (IW > SLOT_W) ? IW : SLOT_W;

   function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
      logic [SX-1:0] wide;
      wide = SX'(idx);
      return wide[SLOT_W-1:0];
   endfunction

   // Registers
   state_type            state_ff, state_in;
   logic                 policy_ff;
   logic [ACT_W-1:0]     active_ff;
   logic [USED-1:0]      valid_ff;
   logic [IW-1:0]        ptr_ff;
   logic [STAMP_W-1:0]   counter_ff;

   logic [CMD_W-1:0]     cmd_ff;
   logic [PID_W-1:0]     pid_ff;
   logic [PAGE_W-1:0]    page_ff;
   logic [FRAME_W-1:0]   frame_ff;
   logic [CW-1:0]        n_ff;
   logic [IW-1:0]        addr_ff;

   logic                 eval_ff;
   logic [IW-1:0]        eval_idx_ff;
   logic                 match_found_ff;
   logic [IW-1:0]        match_idx_ff;
   logic [FRAME_W-1:0]   match_frame_ff;
   logic [STAMP_W-1:0]   match_stamp_ff;
   logic                 free_found_ff;
   logic [IW-1:0]        victim_ff;
   logic [STAMP_W-1:0]   best_ff;
   logic                 any_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [FRAME_W-1:0]   rsp_frame_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;

   // Combinational
   logic                 accept;
   logic [ACT_W:0]       act_ext;
   logic [CW-1:0]        n_now;
   logic [IW-1:0]        last_idx;
   entry_type            rd_entry;
   logic [ENTRY_W-1:0]   rd_bits;
   logic                 e_vld, e_pid, e_tag, e_clr, e_any;
   logic [IW-1:0]        fifo_v, fifo_nxt;
   logic                 do_wr, set_v, clr_v, cnt_inc, ptr_load;
   logic [IW-1:0]        act_idx, ptr_val;
   logic [FRAME_W-1:0]   wr_frame;
   logic [STAMP_W-1:0]   wr_stamp;
   entry_type            wr_entry;
   logic                 res_hit;
   logic [FRAME_W-1:0]   res_frame;
   logic [SLOT_W-1:0]    res_slot;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // active size, 0 acts as 1, capped at table depth
   assign act_ext = {1'b0, active_ff};
   always_comb begin
      priority if (active_ff == '0) begin
         n_now = CW'(1);
      end else if (act_ext > (ACT_W+1)'(USED)) begin
         n_now = CW'(USED);
      end else begin
         n_now = CW'(act_ext);
      end
   end

   assign last_idx = IW'(n_ff - CW'(1));

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 1'b0;
         active_ff <= ACTIVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY: policy_ff <= csr_wdata[0];
            CSR_ACTIVE: active_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_SCAN;
         ST_SCAN: if (addr_ff == last_idx) state_in = ST_TAIL;
         ST_TAIL: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Entry RAM
   ttlb_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(USED)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (do_wr),
      .wr_addr(act_idx),
      .wr_data(wr_entry),
      .rd_en  (state_ff == ST_SCAN),
      .rd_addr(addr_ff),
      .rd_data(rd_bits)
   );

   assign rd_entry = entry_type'(rd_bits);

   // Per-entry checks on the word read last cycle
   always_comb begin
      e_vld = valid_ff[eval_idx_ff];
      e_pid = (rd_entry.proc_id == pid_ff);
      e_tag = e_vld && e_pid && (rd_entry.page_num == page_ff);
      e_clr = eval_ff && (((cmd_ff == CMD_INV_PROC) && e_vld && e_pid) ||
                          (cmd_ff == CMD_FLUSH));
      e_any = eval_ff && e_vld && (((cmd_ff == CMD_INV_PROC) && e_pid) ||
                                   (cmd_ff == CMD_FLUSH));
   end

   // Request capture and sweep address
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         pid_ff   <= req_process_id;
         page_ff  <= req_page_number;
         frame_ff <= req_frame_number;
         n_ff     <= n_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         eval_ff     <= 1'b0;
         eval_idx_ff <= '0;
      end else begin
         eval_ff     <= (state_ff == ST_SCAN);
         eval_idx_ff <= addr_ff;
         if (accept) begin
            addr_ff <= '0;
         end else if (state_ff == ST_SCAN) begin
            addr_ff <= addr_ff + IW'(1);
         end
      end
   end

   // Sweep results: first match, victim (first free slot, else LRU), any cleared
   always_ff @(posedge clock) begin
      if (reset || accept) begin
         match_found_ff <= 1'b0;
         match_idx_ff   <= '0;
         free_found_ff  <= 1'b0;
         victim_ff      <= '0;
         best_ff        <= '1;
         any_ff         <= 1'b0;
      end else if (eval_ff) begin
         if (e_tag && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= eval_idx_ff;
            match_frame_ff <= rd_entry.frame_num;
            match_stamp_ff <= rd_entry.stamp;
         end
         if (!free_found_ff) begin
            if (!e_vld) begin
               free_found_ff <= 1'b1;
               victim_ff     <= eval_idx_ff;
            end else if (rd_entry.stamp < best_ff) begin
               best_ff   <= rd_entry.stamp;
               victim_ff <= eval_idx_ff;
            end
         end
         if (e_any) begin
            any_ff <= 1'b1;
         end
      end
   end

   // FIFO victim, pointer out of range falls back to 0
   always_comb begin
      fifo_v   = (CMPW'(ptr_ff) < CMPW'(n_ff)) ? ptr_ff : '0;
      fifo_nxt = (CMPW'(fifo_v) + CMPW'(1) == CMPW'(n_ff)) ? '0 : fifo_v + IW'(1);
   end

   // Final action of a command
   always_comb begin
      do_wr     = 1'b0;
      set_v     = 1'b0;
      clr_v     = 1'b0;
      cnt_inc   = 1'b0;
      ptr_load  = 1'b0;
      ptr_val   = '0;
      act_idx   = match_idx_ff;
      wr_frame  = frame_ff;
      wr_stamp  = counter_ff;
      res_hit   = 1'b0;
      res_frame = '0;
      res_slot  = '0;
      if (state_ff == ST_DONE) begin
         unique case (cmd_ff)
            CMD_LOOKUP: begin
               if (match_found_ff) begin
                  res_hit   = 1'b1;
                  res_frame = match_frame_ff;
                  res_slot  = to_slot(match_idx_ff);
                  wr_frame  = match_frame_ff;
                  do_wr     = policy_ff;
                  cnt_inc   = policy_ff;
               end
            end
            CMD_INSERT: begin
               do_wr = 1'b1;
               if (match_found_ff) begin
                  res_hit  = 1'b1;
                  res_slot = to_slot(match_idx_ff);
                  wr_stamp = policy_ff ? counter_ff : match_stamp_ff;
                  cnt_inc  = policy_ff;
               end else begin
                  act_idx  = policy_ff ? victim_ff : fifo_v;
                  res_slot = to_slot(act_idx);
                  set_v    = 1'b1;
                  cnt_inc  = 1'b1;
                  ptr_load = !policy_ff;
                  ptr_val  = fifo_nxt;
               end
            end
            CMD_INV_ONE: begin
               if (match_found_ff) begin
                  clr_v    = 1'b1;
                  res_hit  = 1'b1;
                  res_slot = to_slot(match_idx_ff);
               end
            end
            CMD_INV_PROC: res_hit = any_ff;
            CMD_FLUSH: begin
               res_hit  = any_ff;
               ptr_load = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign wr_entry = '{proc_id: pid_ff, page_num: page_ff, frame_num: wr_frame,
                       stamp: wr_stamp};

   // Valid bits, pointer, access counter
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         ptr_ff     <= '0;
         counter_ff <= '0;
      end else begin
         if (e_clr) valid_ff[eval_idx_ff] <= 1'b0;
         if (set_v) valid_ff[act_idx] <= 1'b1;
         if (clr_v) valid_ff[act_idx] <= 1'b0;
         if (ptr_load) ptr_ff <= ptr_val;
         if (cnt_inc) counter_ff <= counter_ff + STAMP_W'(1);
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
      if (state_ff == ST_DONE) begin
         rsp_hit_ff   <= res_hit;
         rsp_frame_ff <= res_frame;
         rsp_slot_ff  <= res_slot;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_frame = rsp_frame_ff;
   assign rsp_slot_index  = rsp_slot_ff;

   // Checks
   `TTLB_ASSERT_NXT(a_done_strobe, clock, reset, state_ff == ST_DONE, rsp_valid && !busy, "result word missing after command end")
   `TTLB_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy && !rsp_valid, "accepted command did not start a sweep")
   `TTLB_ASSERT_IMP(a_frame_zero, clock, reset, rsp_valid && !rsp_hit, rsp_found_frame == '0, "frame nonzero on a miss")
   `TTLB_ASSERT_IMP(a_sweep_range, clock, reset, eval_ff, CMPW'(eval_idx_ff) < CMPW'(n_ff), "sweep beyond active size")

endmodule

`default_nettype wire

// ===== design/ttlb_ram.sv =====
`default_nettype none

module ttlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== bench/tagged_tlb_fifo_lru_core_tb.sv =====
`timescale 1ns / 100ps

module tagged_tlb_fifo_lru_core_tb;
   import ttlb_pkg::*;

   localparam int N_ENT          = DEF_ENTRIES;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PAGE_POOL_N    = 128;
   localparam int PID_POOL_N     = 4;
   localparam int MAX_PRINTS     = 25;

   // commands the block treats as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam logic [PID_W-1:0]   PID_ONES   = {PID_W{1'b1}};
   localparam logic [PAGE_W-1:0]  PAGE_ONES  = {PAGE_W{1'b1}};
   localparam logic [FRAME_W-1:0] FRAME_ONES = {FRAME_W{1'b1}};

   // random phases: policy, raw active size write, length
   localparam int N_PHASES = 10;
   localparam int PH_POLICY [N_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
   localparam int PH_ACTIVE [N_PHASES] = '{64, 64, 8, 8, 1, 0, 127, 17, 5, 100};
   localparam int PH_LEN    [N_PHASES] = '{200, 220, 120, 120, 60, 60, 150, 140, 100, 180};

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [PID_W-1:0]   process_id;
      logic [PAGE_W-1:0]  page_number;
      logic [FRAME_W-1:0] frame_number;
   } tlb_word_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
      logic [SLOT_W-1:0]  slot;
   } tlb_rsp_type;

   // block ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CMD_W-1:0]      req_command = '0;
   logic [PID_W-1:0]      req_process_id = '0;
   logic [PAGE_W-1:0]     req_page_number = '0;
   logic [FRAME_W-1:0]    req_frame_number = '0;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic [FRAME_W-1:0]    rsp_found_frame;
   logic [SLOT_W-1:0]     rsp_slot_index;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // stimulus and expected results
   tlb_word_type cmd_queue[$];
   tlb_rsp_type  expected_rsp_q[$];
   logic         hold_drain = 1'b0;

   // translation table predictor state
   logic                mdl_policy;
   logic [ACT_W-1:0]    mdl_active;
   logic                mdl_valid [N_ENT];
   logic [PID_W-1:0]    mdl_pid   [N_ENT];
   logic [PAGE_W-1:0]   mdl_page  [N_ENT];
   logic [FRAME_W-1:0]  mdl_frame [N_ENT];
   logic [STAMP_W-1:0]  mdl_stamp [N_ENT];
   int                  mdl_fifo_ptr;
   logic [STAMP_W-1:0]  mdl_counter;

   // tag pools so that lookups find something
   logic [PID_W-1:0]    pid_pool  [PID_POOL_N];
   logic [PAGE_W-1:0]   page_pool [PAGE_POOL_N];

   // bookkeeping
   int errors       = 0;
   int cmd_sent     = 0;
   int rsp_seen     = 0;
   int hit_seen     = 0;
   int quiet_cycles = 0;
   int settings     = 0;
   int cmd_count [8];

   tagged_tlb_fifo_lru_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_process_id   (req_process_id),
      .req_page_number  (req_page_number),
      .req_frame_number (req_frame_number),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_found_frame  (rsp_found_frame),
      .rsp_slot_index   (rsp_slot_index),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic int tlb_active_size();
      int a;
      a = int'(mdl_active);
      if (a == 0) a = 1;
      if (a > N_ENT) a = N_ENT;
      return a;
   endfunction

   // first valid active entry with this tag, -1 when none
   function automatic int tlb_find(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page, int n);
      for (int i = 0; i < n; i++) begin
         if (mdl_valid[i] && mdl_pid[i] == pid && mdl_page[i] == page) return i;
      end
      return -1;
   endfunction

   function automatic int tlb_victim(int n);
      int v;
      logic [STAMP_W-1:0] best;
      if (!mdl_policy) begin
         // pointer left beyond a shrunk table restarts at zero
         v = (mdl_fifo_ptr < n) ? mdl_fifo_ptr : 0;
         mdl_fifo_ptr = (v + 1) % n;
         return v;
      end
      best = '1;
      v = 0;
      for (int i = 0; i < n; i++) begin
         if (!mdl_valid[i]) return i;
         if (mdl_stamp[i] < best) begin
            best = mdl_stamp[i];
            v = i;
         end
      end
      return v;
   endfunction

   function automatic void tlb_touch(int idx);
      mdl_stamp[idx] = mdl_counter;
      mdl_counter = mdl_counter + 1'b1;
   endfunction

   function automatic tlb_rsp_type predict_tlb(tlb_word_type w);
      tlb_rsp_type r;
      int n;
      int m;
      int v;
      r = '0;
      n = tlb_active_size();
      case (w.command)
         CMD_LOOKUP: begin
            m = tlb_find(w.process_id, w.page_number, n);
            if (m >= 0) begin
               r.hit   = 1'b1;
               r.frame = mdl_frame[m];
               r.slot  = SLOT_W'(m);
               if (mdl_policy) tlb_touch(m);
            end
         end
         CMD_INSERT: begin
            m = tlb_find(w.process_id, w.page_number, n);
            if (m >= 0) begin
               // update in place
               r.hit        = 1'b1;
               r.slot       = SLOT_W'(m);
               mdl_frame[m] = w.frame_number;
               if (mdl_policy) tlb_touch(m);
            end else begin
               v            = tlb_victim(n);
               mdl_valid[v] = 1'b1;
               mdl_pid[v]   = w.process_id;
               mdl_page[v]  = w.page_number;
               mdl_frame[v] = w.frame_number;
               tlb_touch(v);
               r.slot       = SLOT_W'(v);
            end
         end
         CMD_INV_ONE: begin
            m = tlb_find(w.process_id, w.page_number, n);
            if (m >= 0) begin
               mdl_valid[m] = 1'b0;
               r.hit        = 1'b1;
               r.slot       = SLOT_W'(m);
            end
         end
         CMD_INV_PROC: begin
            for (int i = 0; i < n; i++) begin
               if (mdl_valid[i] && mdl_pid[i] == w.process_id) begin
                  mdl_valid[i] = 1'b0;
                  r.hit        = 1'b1;
               end
            end
         end
         CMD_FLUSH: begin
            // access counter survives a flush
            for (int i = 0; i < n; i++) begin
               if (mdl_valid[i]) r.hit = 1'b1;
               mdl_valid[i] = 1'b0;
               mdl_pid[i]   = '0;
               mdl_page[i]  = '0;
               mdl_frame[i] = '0;
               mdl_stamp[i] = '0;
            end
            mdl_fifo_ptr = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic void push_word(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                     logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
      tlb_word_type w;
      w.command      = cmd;
      w.process_id   = pid;
      w.page_number  = page;
      w.frame_number = frame;
      cmd_queue.push_back(w);
   endfunction

   // random word; tags mostly from the pools, span limits how many pages take part
   function automatic tlb_word_type make_word(int span, int flush_w);
      tlb_word_type w;
      int r;
      logic [63:0] raw;
      r = $urandom_range(999);
      if (r < 350)                     w.command = CMD_LOOKUP;
      else if (r < 800)                w.command = CMD_INSERT;
      else if (r < 900)                w.command = CMD_INV_ONE;
      else if (r < 940)                w.command = CMD_INV_PROC;
      else if (r < 940 + flush_w)      w.command = CMD_FLUSH;
      else if (r < 955 + flush_w)      w.command = CMD_W'($urandom_range(7, 5));
      else                             w.command = CMD_LOOKUP;
      if ($urandom_range(99) < 8) begin
         raw = {$urandom, $urandom};
         w.process_id  = $urandom;
         w.page_number = raw[PAGE_W-1:0];
      end else begin
         w.process_id  = pid_pool[$urandom_range(PID_POOL_N-1)];
         w.page_number = page_pool[$urandom_range(span-1)];
      end
      w.frame_number = $urandom;
      return w;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_POLICY) mdl_policy = data[0];
      else                   mdl_active = data[ACT_W-1:0];
   endtask

   // idle: nothing queued, nothing in the block, nothing expected
   task automatic wait_idle();
      @(negedge clock);
      while (cmd_queue.size() != 0 || start || busy || expected_rsp_q.size() != 0)
         @(negedge clock);
      repeat (2) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // driver: one word at a time from cmd_queue
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      tlb_word_type w;
      int idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         idle_pct = (cmd_sent < 470) ? 38 : (cmd_sent < 940) ? 77 : 0;
         if (start && !busy) begin
            cmd_sent++;
            // now and then wait for the table to drain before the next word
            if ($urandom_range(59) == 0) hold_drain = 1'b1;
         end
         if (!start || !busy) begin
            if (hold_drain && !start && !busy && expected_rsp_q.size() == 0)
               hold_drain = 1'b0;
            if (!hold_drain && cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
               w = cmd_queue.pop_front();
               start            <= 1'b1;
               req_command      <= w.command;
               req_process_id   <= w.process_id;
               req_page_number  <= w.page_number;
               req_frame_number <= w.frame_number;
            end else if (start) begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: check results, then predict the word taken at this edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      tlb_rsp_type e;
      tlb_word_type w;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("result strobe with nothing expected");
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_hit !== e.hit)
                  report_mismatch($sformatf("result %0d hit: got %b expected %b",
                                            rsp_seen, rsp_hit, e.hit));
               if (rsp_found_frame !== e.frame)
                  report_mismatch($sformatf("result %0d found_frame: got %h expected %h",
                                            rsp_seen, rsp_found_frame, e.frame));
               if (rsp_slot_index !== e.slot)
                  report_mismatch($sformatf("result %0d slot_index: got %0d expected %0d",
                                            rsp_seen, rsp_slot_index, e.slot));
               if (e.hit) hit_seen++;
            end
            rsp_seen++;
         end
         if (start && !busy) begin
            w.command      = req_command;
            w.process_id   = req_process_id;
            w.page_number  = req_page_number;
            w.frame_number = req_frame_number;
            cmd_count[w.command]++;
            expected_rsp_q.push_back(predict_tlb(w));
         end
      end
   end

   // cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      int span;
      int flush_w;
      int n;
      logic [CSR_DATA_W-1:0] pol_data;
      logic [63:0] raw;

      // predictor reset state
      mdl_policy   = 1'b0;
      mdl_active   = ACTIVE_RESET;
      mdl_fifo_ptr = 0;
      mdl_counter  = '0;
      for (int i = 0; i < N_ENT; i++) begin
         mdl_valid[i] = 1'b0;
         mdl_pid[i]   = '0;
         mdl_page[i]  = '0;
         mdl_frame[i] = '0;
         mdl_stamp[i] = '0;
      end
      for (int i = 0; i < 8; i++) cmd_count[i] = 0;

      // tag pools with both extremes at the front
      pid_pool[0] = '0;
      pid_pool[1] = PID_ONES;
      for (int i = 2; i < PID_POOL_N; i++) pid_pool[i] = $urandom;
      page_pool[0] = '0;
      page_pool[1] = PAGE_ONES;
      for (int i = 2; i < PAGE_POOL_N; i++) begin
         raw = {$urandom, $urandom};
         page_pool[i] = raw[PAGE_W-1:0];
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      settings++;

      // directed: reset setting, FIFO over 64 entries
      push_word(CMD_LOOKUP, '0, '0, '0);                      // miss on empty table
      push_word(CMD_INSERT, '0, '0, '0);                      // fill slot 0
      push_word(CMD_INSERT, PID_ONES, PAGE_ONES, FRAME_ONES); // fill slot 1
      push_word(CMD_INSERT, '0, PAGE_ONES, 32'hA5A5_5A5A);
      push_word(CMD_LOOKUP, PID_ONES, PAGE_ONES, '0);         // hit, all-ones frame
      push_word(CMD_INSERT, '0, '0, 32'h1234_5678);           // update in place
      push_word(CMD_LOOKUP, '0, '0, '0);
      push_word(CMD_INV_ONE, PID_ONES, PAGE_ONES, '0);        // hit
      push_word(CMD_INV_ONE, PID_ONES, PAGE_ONES, '0);        // now a miss
      push_word(CMD_INSERT, 32'd7, 52'd7, 32'd7);
      push_word(CMD_SPARE_LO, PID_ONES, PAGE_ONES, FRAME_ONES);
      push_word(CMD_SPARE_HI, '0, '0, '0);
      push_word(CMD_INV_PROC, '0, '0, '0);                    // clears two entries
      push_word(CMD_INV_PROC, '0, '0, '0);                    // nothing left for it
      push_word(CMD_FLUSH, '0, '0, '0);
      push_word(CMD_FLUSH, '0, '0, '0);                       // flush of an empty table
      push_word(CMD_INSERT, 32'd1, 52'd1, 32'd11);
      push_word(CMD_INSERT, 32'd2, 52'd2, 32'd22);
      push_word(CMD_INSERT, 32'd3, 52'd3, 32'd33);
      wait_idle();

      // shrink below the FIFO pointer: victim restarts at zero
      write_csr(CSR_ACTIVE, 7'd2);
      settings++;
      push_word(CMD_INSERT, 32'd4, 52'd4, 32'd44);
      push_word(CMD_INSERT, 32'd5, 52'd5, 32'd55);
      wait_idle();

      // LRU over three full entries
      write_csr(CSR_POLICY, 7'd1);
      write_csr(CSR_ACTIVE, 7'd3);
      settings++;
      push_word(CMD_LOOKUP, 32'd4, 52'd4, '0);
      push_word(CMD_INSERT, 32'd6, 52'd6, 32'd66);
      push_word(CMD_INSERT, 32'd8, 52'd8, 32'd88);
      wait_idle();

      // random phases
      for (int p = 0; p < N_PHASES; p++) begin
         pol_data    = CSR_DATA_W'($urandom_range(127));
         pol_data[0] = PH_POLICY[p][0];
         write_csr(CSR_POLICY, pol_data);
         write_csr(CSR_ACTIVE, CSR_DATA_W'(PH_ACTIVE[p]));
         settings++;
         n       = tlb_active_size();
         span    = n + n / 2 + 2;
         if (span > PAGE_POOL_N) span = PAGE_POOL_N;
         flush_w = (n >= 17) ? 6 : 30;
         for (int k = 0; k < PH_LEN[p]; k++) cmd_queue.push_back(make_word(span, flush_w));
         wait_idle();
      end

      repeat (80) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", expected_rsp_q.size()));

      $display("Ran %0d commands over %0d register settings: lookup %0d, insert %0d, inv %0d,",
               cmd_sent, settings, cmd_count[CMD_LOOKUP], cmd_count[CMD_INSERT],
               cmd_count[CMD_INV_ONE]);
      $display("inv-process %0d, flush %0d, spare %0d; %0d results, %0d hits, %0d errors",
               cmd_count[CMD_INV_PROC], cmd_count[CMD_FLUSH],
               cmd_count[5] + cmd_count[6] + cmd_count[7], rsp_seen, hit_seen, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
